### hdl/dcd_pkg.sv
// Shared types, constants and calendar tables for the date check and cycle day unit.
// Used by every module under hdl; depends on nothing.
package dcd_pkg;

  localparam int YEAR_WIDTH = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int ERR_W      = 2;
  localparam int OFF_W      = 22;
  localparam int PHASE_W    = 8;
  localparam int CFG_W      = 14;
  localparam int CFG_IDX_W  = 2;

  // Day counts since year zero need one more bit than the offset.
  localparam int DB_W       = 23;
  localparam int SUM_W      = 24;
  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

  // Year split by 100 through a reciprocal multiply: exact for 14-bit years.
  localparam int          HUND_W     = 27;
  localparam int          HUND_SHIFT = 19;
  localparam logic [12:0] HUND_RECIP = 13'd5243;

  // Restoring divider for the phase: dividend and divisor widths.
  localparam int DIV_W      = OFF_W;
  localparam int DVSR_W     = PHASE_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_YEAR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DAYS  = 2'd2;

  localparam logic [YEAR_WIDTH-1:0] EPOCH_RST  = YEAR_WIDTH'(1990);
  localparam logic [PHASE_W-1:0]    CYCLE_RST  = 8'd5;
  localparam logic [PHASE_W-1:0]    ACTIVE_RST = 8'd3;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_YEAR  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_MONTH = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DAY   = 2'd3;

  typedef enum logic {
    DSEL_YEAR,
    DSEL_EPOCH
  } dsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YSPLIT,
    ST_YSAVE,
    ST_ESPLIT,
    ST_ESAVE,
    ST_CALC,
    ST_PDIV,
    ST_PWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  load_in;
    logic  split;
    dsel_t year_sel;
    logic  save_year;
    logic  save_epoch;
    logic  calc;
    logic  div_start;
    logic  load_out;
  } dcd_cmd_t;

  typedef struct packed {
    logic div_done;
  } dcd_sts_t;

  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] v;
    case (m)
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] v;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
      4'd2:    v = leap ? 5'd29 : 5'd28;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

### hdl/dcd_div.sv
// Restoring divider for the cycle phase, one quotient bit per cycle.
// Depends on dcd_pkg for widths.
module dcd_div import dcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic [DVSR_W-1:0] remainder,
  output logic              done
);

  logic [DIV_W-1:0]     quo_r;
  logic [DVSR_W-1:0]    rem_r;
  logic [DVSR_W-1:0]    dvsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;

  logic [DVSR_W:0]      shifted;
  logic [DVSR_W:0]      trial;
  logic                 fits;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvsr_r};
  assign trial   = shifted - {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= DIV_CNT_W'(DIV_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (cnt_r != '0) begin
      // shift the next dividend bit in, subtract where it fits
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? trial[DVSR_W-1:0] : shifted[DVSR_W-1:0];
    end
  end

  assign remainder = rem_r;
  assign done      = done_r;

endmodule

### hdl/dcd_datapath.sv
// Datapath: input latch, day counts, date check, offset and phase, result register.
// Depends on dcd_pkg and instantiates dcd_div.
module dcd_datapath import dcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dcd_cmd_t              cmd,
  output dcd_sts_t              sts,
  input  logic [YEAR_WIDTH-1:0] in_year,
  input  logic [MONTH_W-1:0]    in_month,
  input  logic [DAY_W-1:0]      in_day,
  input  logic [YEAR_WIDTH-1:0] epoch_year,
  input  logic [PHASE_W-1:0]    cycle_length,
  input  logic [PHASE_W-1:0]    active_days,
  output logic [ERR_W-1:0]      res_error_code,
  output logic [OFF_W-1:0]      res_day_offset,
  output logic [PHASE_W-1:0]    res_cycle_phase,
  output logic                  res_active_flag
);

  logic [YEAR_WIDTH-1:0] year_r;
  logic [MONTH_W-1:0]    month_r;
  logic [DAY_W-1:0]      day_r;
  logic [7:0]            q100_r;
  logic [6:0]            r100_r;
  logic [DB_W-1:0]       dby_r;
  logic [DB_W-1:0]       dbe_r;
  logic                  leap_r;
  logic [ERR_W-1:0]      err_r;
  logic [OFF_W-1:0]      off_r;

  logic [ERR_W-1:0]      err_out_r;
  logic [OFF_W-1:0]      off_out_r;
  logic [PHASE_W-1:0]    phase_out_r;
  logic                  active_out_r;

  logic [DVSR_W-1:0]     div_divisor;
  logic [DVSR_W-1:0]     div_rem;
  logic                  div_done;

  logic [YEAR_WIDTH-1:0] db_year;
  logic [HUND_W-1:0]     hund_prod;
  logic [7:0]            q100;
  logic [YEAR_WIDTH-1:0] r100_full;
  logic [DB_W-1:0]       db_val;
  logic                  year_leap;

  logic [DAY_W-1:0]      mlen;
  logic [ERR_W-1:0]      err_calc;
  logic [SUM_W-1:0]      off_sum;
  logic [OFF_W-1:0]      off_sat;
  logic [PHASE_W-1:0]    phase;

  // The offset goes through the divider by the cycle length; a zero cycle length divides by one.
  assign div_divisor = (cycle_length == '0) ? DVSR_W'(1) : DVSR_W'(cycle_length);

  dcd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (off_r),
    .divisor   (div_divisor),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign sts.div_done = div_done;

  assign db_year = (cmd.year_sel == DSEL_EPOCH) ? epoch_year : year_r;

  // Split the selected year into y/100 and y%100 by a reciprocal multiply.
  assign hund_prod = HUND_W'(db_year) * HUND_W'(HUND_RECIP);
  assign q100      = hund_prod[HUND_W-1:HUND_SHIFT];
  assign r100_full = db_year - YEAR_WIDTH'(q100) * YEAR_WIDTH'(100);

  // Days from January 1 of year zero, from y, y/100 and y%100.
  always_comb begin
    logic [14:0] by4;
    logic [14:0] by100;
    logic [14:0] by400;
    logic [14:0] leaps;
    by4    = 15'(({1'b0, db_year} + 15'd3) >> 2);
    by100  = 15'(q100_r) + 15'(r100_r != '0);
    by400  = 15'(q100_r >> 2) + 15'(!((r100_r == '0) && (q100_r[1:0] == 2'b00)));
    leaps  = by4 - by100 + by400;
    db_val = DB_W'(db_year) * DB_W'(365) + DB_W'(leaps);
  end

  assign year_leap = (db_year[1:0] == 2'b00) &&
                     ((r100_r != '0) || (q100_r[1:0] == 2'b00));

  // Date check: year first, then month, then day.
  assign mlen = month_len(month_r, leap_r);

  always_comb begin
    if (year_r < epoch_year) begin
      err_calc = ERR_YEAR;
    end else if (!(month_r inside {[4'd1:4'd12]})) begin
      err_calc = ERR_MONTH;
    end else if ((day_r == '0) || (day_r > mlen)) begin
      err_calc = ERR_DAY;
    end else begin
      err_calc = ERR_NONE;
    end
  end

  assign off_sum = SUM_W'(dby_r) - SUM_W'(dbe_r) + SUM_W'(month_start(month_r))
                 + SUM_W'(day_r) - SUM_W'(1)
                 + SUM_W'((month_r > 4'd2) && leap_r);
  assign off_sat = (off_sum[SUM_W-1:OFF_W] != '0) ? OFF_MAX : off_sum[OFF_W-1:0];

  assign phase = div_rem;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      year_r  <= in_year;
      month_r <= in_month;
      day_r   <= in_day;
    end
    if (cmd.split) begin
      q100_r <= q100;
      r100_r <= r100_full[6:0];
    end
    if (cmd.save_year) begin
      dby_r  <= db_val;
      leap_r <= year_leap;
    end
    if (cmd.save_epoch) begin
      dbe_r <= db_val;
    end
    if (cmd.calc) begin
      err_r <= err_calc;
      off_r <= (err_calc == ERR_NONE) ? off_sat : '0;
    end
    if (cmd.load_out) begin
      err_out_r    <= err_r;
      off_out_r    <= off_r;
      phase_out_r  <= (err_r == ERR_NONE) ? phase : '0;
      active_out_r <= (err_r == ERR_NONE) && (phase < active_days);
    end
  end

  assign res_error_code  = err_out_r;
  assign res_day_offset  = off_out_r;
  assign res_cycle_phase = phase_out_r;
  assign res_active_flag = active_out_r;

endmodule

### hdl/dcd_ctrl.sv
// Controller: sequences the two year splits, the check and the phase division,
// and owns both handshakes. Depends on dcd_pkg for the state, command and status types.
module dcd_ctrl import dcd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dcd_cmd_t cmd,
  input  dcd_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.year_sel  = DSEL_YEAR;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_YSPLIT;
        end
      end
      ST_YSPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_YSAVE;
      end
      ST_YSAVE: begin
        cmd.save_year = 1'b1;
        state_nxt     = ST_ESPLIT;
      end
      ST_ESPLIT: begin
        cmd.year_sel = DSEL_EPOCH;
        cmd.split    = 1'b1;
        state_nxt    = ST_ESAVE;
      end
      ST_ESAVE: begin
        cmd.year_sel   = DSEL_EPOCH;
        cmd.save_epoch = 1'b1;
        state_nxt      = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_PDIV;
      end
      ST_PDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/date_check_and_cycle_day_unit.sv
// Top level: stream ports, configuration registers, controller and datapath.
// Depends on dcd_pkg, dcd_ctrl and dcd_datapath.
//
//   channel  direction  group                         moves
//   in_      slave      in_tvalid/in_tready/in_tdata  one date request
//   out_     master     out_tvalid/out_tready/out_tdata one check and cycle result
//   cfg_     write      cfg_we/cfg_index/cfg_wdata    epoch, cycle length, active days
//
// From acceptance to result, a request passes through a split by 100 and a day
// count for the request year, then a split and day count for the epoch, the check,
// and the offset modulo cycle length through a 22-step restoring divider.
// One request is in work at a time; the next is taken the cycle after the current
// one has moved into the result register, which holds it while out_tready is low.
// Reset clears the controller and loads the register defaults (1990, 5, 3).
module date_check_and_cycle_day_unit import dcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [13:0] year, [17:14] month, [22:18] day, [23] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] error_code, [23:2] day_offset, [31:24] cycle_phase, [32] active_flag,
  // [39:33] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [YEAR_WIDTH-1:0] epoch_year_r;
  logic [PHASE_W-1:0]    cycle_length_r;
  logic [PHASE_W-1:0]    active_days_r;

  dcd_cmd_t              cmd;
  dcd_sts_t              sts;

  logic [ERR_W-1:0]      res_error_code;
  logic [OFF_W-1:0]      res_day_offset;
  logic [PHASE_W-1:0]    res_cycle_phase;
  logic                  res_active_flag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_year_r   <= EPOCH_RST;
      cycle_length_r <= CYCLE_RST;
      active_days_r  <= ACTIVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EPOCH_YEAR:   epoch_year_r   <= cfg_wdata[YEAR_WIDTH-1:0];
        CFG_CYCLE_LENGTH: cycle_length_r <= cfg_wdata[PHASE_W-1:0];
        CFG_ACTIVE_DAYS:  active_days_r  <= cfg_wdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  dcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dcd_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_year         (in_tdata[13:0]),
    .in_month        (in_tdata[17:14]),
    .in_day          (in_tdata[22:18]),
    .epoch_year      (epoch_year_r),
    .cycle_length    (cycle_length_r),
    .active_days     (active_days_r),
    .res_error_code  (res_error_code),
    .res_day_offset  (res_day_offset),
    .res_cycle_phase (res_cycle_phase),
    .res_active_flag (res_active_flag)
  );

  assign out_tdata = {7'd0, res_active_flag, res_cycle_phase, res_day_offset, res_error_code};

endmodule
